[rtl/core/fcs_pkg.sv]
// ----------------------------------------------------------------------------
// fcs_pkg
// shared types, codes and constants of the framed command sender
// ----------------------------------------------------------------------------
package fcs_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  kind_t;
  typedef logic [2:0]  res_code_t;
  typedef logic [15:0] ticks_t;
  typedef logic [2:0]  attempts_t;

  // item kinds
  localparam kind_t KIND_PAYLOAD  = 3'd0;
  localparam kind_t KIND_START    = 3'd1;
  localparam kind_t KIND_TX_READY = 3'd2;
  localparam kind_t KIND_RX_BYTE  = 3'd3;
  localparam kind_t KIND_TICK     = 3'd4;

  // result codes
  localparam res_code_t RES_OK         = 3'd0;
  localparam res_code_t RES_BAD_REPLY  = 3'd1;
  localparam res_code_t RES_BAD_STATUS = 3'd2;
  localparam res_code_t RES_TIMEOUT    = 3'd3;
  localparam res_code_t RES_BUSY       = 3'd4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT = 1'd1;

  localparam ticks_t    TIMEOUT_RST = 16'd500;
  localparam attempts_t ATTEMPT_RST = 3'd3;
  localparam ticks_t    TICK_MAX    = 16'hFFFF;

  // frame and reply layout
  localparam byte_t HDR_BYTE      = 8'h5E;
  localparam byte_t REPLY_LEN     = 8'h03;
  localparam int unsigned REPLY_BYTES   = 7;
  localparam int unsigned REPLY_CNT_W   = 3;
  localparam int unsigned STATUS_POS    = 5;
  localparam int unsigned PAYLOAD_START = 5;

  localparam int unsigned INFO_BYTES_DEF = 128;

  // phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_SEND = 3'b010,
    PH_WAIT = 3'b100
  } phase_t;

endpackage

[rtl/core/fcs_in_if.sv]
// ----------------------------------------------------------------------------
// fcs_in_if
// input channel: one event word per handshake
// ----------------------------------------------------------------------------
interface fcs_in_if;
  import fcs_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  byte_t data_byte;
  byte_t command_code;
  logic  wait_reply;
  logic  wait_forever;

  modport source (output valid, output kind, output data_byte, output command_code,
                  output wait_reply, output wait_forever, input ready);
  modport sink   (input valid, input kind, input data_byte, input command_code,
                  input wait_reply, input wait_forever, output ready);
endinterface

[rtl/core/fcs_out_if.sv]
// ----------------------------------------------------------------------------
// fcs_out_if
// result channel: one result word per handshake
// ----------------------------------------------------------------------------
interface fcs_out_if;
  import fcs_pkg::*;

  logic      valid;
  logic      ready;
  logic      tx_valid;
  byte_t     tx_byte;
  logic      tx_frame_end;
  logic      done_res;
  res_code_t result_code;
  byte_t     reply_status;
  logic      busy_res;

  modport source (output valid, output tx_valid, output tx_byte, output tx_frame_end,
                  output done_res, output result_code, output reply_status,
                  output busy_res, input ready);
  modport sink   (input valid, input tx_valid, input tx_byte, input tx_frame_end,
                  input done_res, input result_code, input reply_status,
                  input busy_res, output ready);
endinterface

[rtl/core/framed_command_sender_with_retry_core.sv]
// ----------------------------------------------------------------------------
// framed_command_sender_with_retry_core
// builds command frames, sends them byte by byte, checks replies, retries
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one event word per handshake: payload byte load, start
//   command, transmitter ready, received reply byte or millisecond tick
//   out_ch returns exactly one result word for every accepted event word:
//   the frame byte to send (if any), the command result and the busy flag
//   cfg_we / cfg_index / cfg_data write the reply timeout (index 0) and the
//   attempt limit (index 1); write them only while the block is idle
// timing
//   every event is handled in one pass of logic between the input handshake
//   and the result register, so its result is valid one cycle after accept
//   and one word is taken per cycle back to back
//   payload bytes sit in a ram with registered read; the address follows the
//   next send position, so the byte is already read out when ready arrives
// reset
//   rst_n (synchronous) returns to idle with empty payload, sequence zero,
//   timeout 500 ticks and attempt limit 3; no clearing pass is needed
// stall
//   while out_ch is stalled with a word held, in_ch.ready stays low
//   and no state moves
// ----------------------------------------------------------------------------
module framed_command_sender_with_retry_core #(
  parameter int unsigned INFO_BYTES = fcs_pkg::INFO_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fcs_in_if.sink                          in_ch,
  fcs_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [fcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fcs_pkg::*;

  localparam int unsigned IDX_W = (INFO_BYTES > 1) ? $clog2(INFO_BYTES) : 1;
  localparam int unsigned CNT_W = $clog2(INFO_BYTES + 1);
  localparam int unsigned POS_W = $clog2(INFO_BYTES + PAYLOAD_START + 1);

  // configuration registers
  ticks_t    timeout_r;
  attempts_t attempt_limit_r;

  // block state
  phase_t                 phase_r, phase_nxt;
  logic [CNT_W-1:0]       payload_count_r, payload_count_nxt;
  byte_t                  payload_sum_r, payload_sum_nxt;   // running sum of loaded bytes
  byte_t                  seq_r, seq_nxt;
  byte_t                  checksum_r, checksum_nxt;
  logic [POS_W-1:0]       send_pos_r, send_pos_nxt;
  attempts_t              attempts_r, attempts_nxt;
  byte_t                  reply_r [REPLY_BYTES-1];          // last byte is checked on arrival
  logic [REPLY_CNT_W-1:0] reply_cnt_r, reply_cnt_nxt;
  ticks_t                 tick_r, tick_nxt;
  byte_t                  cmd_r, cmd_nxt;
  logic                   wait_reply_r, wait_reply_nxt;
  logic                   wait_forever_r, wait_forever_nxt;

  // result register
  logic      out_valid_r;
  logic      tx_valid_r, tx_valid_nxt;
  byte_t     tx_byte_r, tx_byte_nxt;
  logic      tx_end_r, tx_end_nxt;
  logic      done_r, done_nxt;
  res_code_t code_r, code_nxt;
  byte_t     status_r, status_nxt;
  logic      busy_r;

  logic accept;
  logic ram_we;
  logic [IDX_W-1:0] ram_raddr;
  logic [POS_W-1:0] rd_offset;
  byte_t ram_rdata;
  byte_t frame_len;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign frame_len   = 8'(payload_count_r) + 8'd2;

  // payload store
  assign ram_we    = accept && (in_ch.kind == KIND_PAYLOAD) && (phase_r == PH_IDLE) &&
                     (payload_count_r < CNT_W'(INFO_BYTES));
  assign rd_offset = send_pos_nxt - POS_W'(PAYLOAD_START);
  assign ram_raddr = rd_offset[IDX_W-1:0];

  fcs_ram #(
    .WIDTH (8),
    .DEPTH (INFO_BYTES)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (payload_count_r[IDX_W-1:0]),
    .wdata (in_ch.data_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // event handling
  always_comb begin
    logic  give_up;
    logic  good;
    byte_t rsum;
    ticks_t tick_inc;
    res_code_t fail_code;

    give_up   = 1'b0;
    good      = 1'b0;
    rsum      = '0;
    tick_inc  = '0;
    fail_code = RES_OK;

    phase_nxt         = phase_r;
    payload_count_nxt = payload_count_r;
    payload_sum_nxt   = payload_sum_r;
    seq_nxt           = seq_r;
    checksum_nxt      = checksum_r;
    send_pos_nxt      = send_pos_r;
    attempts_nxt      = attempts_r;
    reply_cnt_nxt     = reply_cnt_r;
    tick_nxt          = tick_r;
    cmd_nxt           = cmd_r;
    wait_reply_nxt    = wait_reply_r;
    wait_forever_nxt  = wait_forever_r;

    tx_valid_nxt = 1'b0;
    tx_byte_nxt  = '0;
    tx_end_nxt   = 1'b0;
    done_nxt     = 1'b0;
    code_nxt     = RES_OK;
    status_nxt   = '0;

    if (accept) begin
      case (in_ch.kind)
        KIND_PAYLOAD: begin
          if (ram_we) begin
            payload_count_nxt = payload_count_r + CNT_W'(1);
            payload_sum_nxt   = payload_sum_r + in_ch.data_byte;
          end
        end
        KIND_START: begin
          if (phase_r != PH_IDLE) begin
            done_nxt = 1'b1;
            code_nxt = RES_BUSY;
          end else begin
            checksum_nxt     = frame_len + in_ch.command_code + payload_sum_r;
            cmd_nxt          = in_ch.command_code;
            wait_reply_nxt   = in_ch.wait_reply;
            wait_forever_nxt = in_ch.wait_forever;
            phase_nxt        = PH_SEND;
            send_pos_nxt     = '0;
            attempts_nxt     = 3'd1;
            reply_cnt_nxt    = '0;
            tick_nxt         = '0;
          end
        end
        KIND_TX_READY: begin
          if (phase_r == PH_SEND) begin
            tx_valid_nxt = 1'b1;
            send_pos_nxt = send_pos_r + POS_W'(1);
            if (send_pos_r < POS_W'(2)) begin
              tx_byte_nxt = HDR_BYTE;
            end else if (send_pos_r == POS_W'(2)) begin
              tx_byte_nxt = seq_r;
            end else if (send_pos_r == POS_W'(3)) begin
              tx_byte_nxt = frame_len;
            end else if (send_pos_r == POS_W'(4)) begin
              tx_byte_nxt = cmd_r;
            end else if (send_pos_r <
                         POS_W'(PAYLOAD_START) + POS_W'(payload_count_r)) begin
              tx_byte_nxt = ram_rdata;
            end else begin
              tx_byte_nxt = checksum_r;
              tx_end_nxt  = 1'b1;
              if (wait_reply_r) begin
                phase_nxt     = PH_WAIT;
                reply_cnt_nxt = '0;
                tick_nxt      = '0;
              end else begin
                done_nxt = 1'b1;
                give_up  = 1'b1;
              end
            end
          end
        end
        KIND_RX_BYTE: begin
          if (phase_r == PH_WAIT) begin
            if (reply_cnt_r == REPLY_CNT_W'(REPLY_BYTES - 1)) begin
              // group complete, the incoming byte is the reply checksum
              rsum = reply_r[3] + reply_r[4] + reply_r[STATUS_POS];
              good = (reply_r[0] == HDR_BYTE) && (reply_r[1] == HDR_BYTE) &&
                     (reply_r[2] == seq_r) && (reply_r[3] == REPLY_LEN) &&
                     (reply_r[4] == cmd_r) && (rsum == in_ch.data_byte);
              status_nxt    = reply_r[STATUS_POS];
              reply_cnt_nxt = '0;
              if (!good) begin
                fail_code = RES_BAD_REPLY;
              end else if (reply_r[STATUS_POS] != 8'd0) begin
                fail_code = RES_BAD_STATUS;
              end
              if (fail_code == RES_OK) begin
                done_nxt = 1'b1;
                give_up  = 1'b1;
              end else if (attempts_r < attempt_limit_r) begin
                attempts_nxt  = attempts_r + 3'd1;
                phase_nxt     = PH_SEND;
                send_pos_nxt  = '0;
                tick_nxt      = '0;
              end else begin
                done_nxt = 1'b1;
                code_nxt = fail_code;
                give_up  = 1'b1;
              end
            end else begin
              reply_cnt_nxt = reply_cnt_r + REPLY_CNT_W'(1);
            end
          end
        end
        KIND_TICK: begin
          if (phase_r == PH_WAIT && !wait_forever_r) begin
            tick_inc = (tick_r < TICK_MAX) ? tick_r + 16'd1 : tick_r;
            tick_nxt = tick_inc;
            if (tick_inc >= timeout_r) begin
              if (attempts_r < attempt_limit_r) begin
                attempts_nxt  = attempts_r + 3'd1;
                phase_nxt     = PH_SEND;
                send_pos_nxt  = '0;
                reply_cnt_nxt = '0;
                tick_nxt      = '0;
              end else begin
                done_nxt = 1'b1;
                code_nxt = RES_TIMEOUT;
                give_up  = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase

      // command finished: next sequence number, payload emptied
      if (give_up) begin
        phase_nxt         = PH_IDLE;
        seq_nxt           = seq_r + 8'd1;
        payload_count_nxt = '0;
        payload_sum_nxt   = '0;
        send_pos_nxt      = '0;
        reply_cnt_nxt     = '0;
        tick_nxt          = '0;
        attempts_nxt      = '0;
      end
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r       <= TIMEOUT_RST;
      attempt_limit_r <= ATTEMPT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REPLY_TIMEOUT: timeout_r       <= cfg_data;
        CFG_ATTEMPT_LIMIT: attempt_limit_r <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      payload_count_r <= '0;
      payload_sum_r   <= '0;
      seq_r           <= '0;
      checksum_r      <= '0;
      send_pos_r      <= '0;
      attempts_r      <= '0;
      reply_cnt_r     <= '0;
      tick_r          <= '0;
      cmd_r           <= '0;
      wait_reply_r    <= 1'b0;
      wait_forever_r  <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      payload_count_r <= payload_count_nxt;
      payload_sum_r   <= payload_sum_nxt;
      seq_r           <= seq_nxt;
      checksum_r      <= checksum_nxt;
      send_pos_r      <= send_pos_nxt;
      attempts_r      <= attempts_nxt;
      reply_cnt_r     <= reply_cnt_nxt;
      tick_r          <= tick_nxt;
      cmd_r           <= cmd_nxt;
      wait_reply_r    <= wait_reply_nxt;
      wait_forever_r  <= wait_forever_nxt;
    end
  end

  // reply bytes gathered at the running count
  always_ff @(posedge clk) begin
    if (accept && in_ch.kind == KIND_RX_BYTE && phase_r == PH_WAIT &&
        reply_cnt_r < REPLY_CNT_W'(REPLY_BYTES - 1)) begin
      reply_r[reply_cnt_r] <= in_ch.data_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_valid_r <= tx_valid_nxt;
      tx_byte_r  <= tx_byte_nxt;
      tx_end_r   <= tx_end_nxt;
      done_r     <= done_nxt;
      code_r     <= code_nxt;
      status_r   <= status_nxt;
      busy_r     <= (phase_nxt != PH_IDLE);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.tx_valid     = tx_valid_r;
  assign out_ch.tx_byte      = tx_byte_r;
  assign out_ch.tx_frame_end = tx_end_r;
  assign out_ch.done_res     = done_r;
  assign out_ch.result_code  = code_r;
  assign out_ch.reply_status = status_r;
  assign out_ch.busy_res     = busy_r;

  // checks
  a_busy_reject_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r && code_r == RES_BUSY) |-> busy_r)
    else $error("busy rejection reported while idle");

  a_frame_end_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && tx_end_r) |-> tx_valid_r)
    else $error("frame end flagged without a frame byte");

  a_idle_no_attempts: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (attempts_r == 3'd0 && send_pos_r == '0))
    else $error("idle with attempt state left over");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(phase_r) && $stable(send_pos_r))
    else $error("state moved while the result word was stalled");

endmodule

[rtl/core/fcs_ram.sv]
// ----------------------------------------------------------------------------
// fcs_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module fcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
